// File: sv/kplre_pkg.sv
// ----------------------------------------------------------------------------
// kplre_pkg: shared types and constants for the key event scanner
// Item layouts, threshold register set and per-key step interface.
// ----------------------------------------------------------------------------
package kplre_pkg;

  localparam int unsigned NumKeysDefault = 8;
  localparam int unsigned KeyFieldW      = 8;
  localparam int unsigned AgeW           = 16;
  localparam int unsigned CfgIdxW        = 2;

  localparam logic [AgeW-1:0] AgeMax            = '1;
  localparam logic [AgeW-1:0] LongPressReset    = AgeW'(100);
  localparam logic [AgeW-1:0] RepeatDelayReset  = AgeW'(50);
  localparam logic [AgeW-1:0] RepeatPeriodReset = AgeW'(20);

  typedef enum logic [CfgIdxW-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_REPEAT_DELAY = 2'd1,
    REG_REPEAT_PERIOD = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [KeyFieldW-1:0] pressed_keys;
    logic                 listener_present;
  } in_item_t;

  typedef struct packed {
    logic [KeyFieldW-1:0] press_events;
    logic [KeyFieldW-1:0] release_events;
    logic [KeyFieldW-1:0] long_press_events;
    logic [KeyFieldW-1:0] repeat_events;
  } out_item_t;

  typedef struct packed {
    logic [AgeW-1:0] long_press_ticks;
    logic [AgeW-1:0] repeat_delay_ticks;
    logic [AgeW-1:0] repeat_period_ticks;
  } cfg_t;

  // Per-key flags and both shared ages, as seen by the step unit
  typedef struct packed {
    logic            now;
    logic            held;
    logic            long_done;
    logic            repeating;
    logic [AgeW-1:0] long_age;
    logic [AgeW-1:0] repeat_age;
  } key_ctx_t;

  typedef struct packed {
    logic            held;
    logic            long_done;
    logic            repeating;
    logic [AgeW-1:0] long_age;
    logic [AgeW-1:0] repeat_age;
    logic            ev_press;
    logic            ev_release;
    logic            ev_long;
    logic            ev_repeat;
  } key_res_t;

endpackage

// File: sv/kplre_cfg_regs.sv
// ----------------------------------------------------------------------------
// kplre_cfg_regs: threshold register file
// Three 16-bit tick thresholds, written through a valid/ready port.
// ----------------------------------------------------------------------------
module kplre_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kplre_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kplre_pkg::AgeW-1:0]   cfg_data_i,
  output kplre_pkg::cfg_t              cfg_o
);
  import kplre_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks    <= LongPressReset;
      cfg_q.repeat_delay_ticks  <= RepeatDelayReset;
      cfg_q.repeat_period_ticks <= RepeatPeriodReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LONG_PRESS:    cfg_q.long_press_ticks    <= cfg_data_i;
        REG_REPEAT_DELAY:  cfg_q.repeat_delay_ticks  <= cfg_data_i;
        REG_REPEAT_PERIOD: cfg_q.repeat_period_ticks <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

// File: sv/kplre_key_step.sv
// ----------------------------------------------------------------------------
// kplre_key_step: shared per-key evaluation unit
// Compares the shared ages with the thresholds for one key and returns the
// updated key flags, ages and event bits.
// ----------------------------------------------------------------------------
module kplre_key_step (
  input  kplre_pkg::key_ctx_t ctx_i,
  input  kplre_pkg::cfg_t     cfg_i,
  output kplre_pkg::key_res_t res_o
);
  import kplre_pkg::*;

  logic long_hit;
  logic first_rep_hit;
  logic next_rep_hit;

  assign long_hit      = ctx_i.long_age > cfg_i.long_press_ticks;
  assign first_rep_hit = ctx_i.repeat_age > cfg_i.repeat_delay_ticks;
  assign next_rep_hit  = ctx_i.repeat_age > cfg_i.repeat_period_ticks;

  always_comb begin
    res_o.held       = ctx_i.held;
    res_o.long_done  = ctx_i.long_done;
    res_o.repeating  = ctx_i.repeating;
    res_o.long_age   = ctx_i.long_age;
    res_o.repeat_age = ctx_i.repeat_age;
    res_o.ev_press   = 1'b0;
    res_o.ev_release = 1'b0;
    res_o.ev_long    = 1'b0;
    res_o.ev_repeat  = 1'b0;
    if (ctx_i.now && !ctx_i.held) begin
      // new press: restart both ages
      res_o.held       = 1'b1;
      res_o.long_done  = 1'b0;
      res_o.repeating  = 1'b0;
      res_o.ev_press   = 1'b1;
      res_o.long_age   = '0;
      res_o.repeat_age = '0;
    end else if (!ctx_i.now && ctx_i.held) begin
      res_o.held       = 1'b0;
      res_o.ev_release = !ctx_i.long_done;
    end else if (ctx_i.now && ctx_i.held) begin
      if (!ctx_i.long_done && long_hit) begin
        res_o.long_age  = '0;
        res_o.long_done = 1'b1;
        res_o.ev_long   = 1'b1;
      end
      if (!ctx_i.repeating) begin
        if (first_rep_hit) begin
          res_o.repeat_age = '0;
          res_o.repeating  = 1'b1;
          res_o.ev_repeat  = 1'b1;
        end
      end else if (next_rep_hit) begin
        res_o.repeat_age = '0;
        res_o.ev_repeat  = 1'b1;
      end
    end
  end

endmodule

// File: sv/key_press_long_repeat_events.sv
// ----------------------------------------------------------------------------
// key_press_long_repeat_events: press / long press / auto-repeat scanner
// Walks the keys of one poll tick through a shared evaluation unit, one key
// per cycle, when a listener is present, and returns one set of per-key event masks.
// ----------------------------------------------------------------------------
// Sequence: an accepted item goes through the key walk (ST_SCAN), which is skipped
//   when the listener flag is clear, then ST_FINISH, which loads the output register once it is free.
// A new item is taken only in ST_IDLE, after the previous result has been loaded;
//   the key walk visits one key per cycle through the shared step unit.
// Reset: asynchronous, active low; clears key flags, ages, the sequencer and
//   the output valid, and loads the threshold defaults 100 / 50 / 20.
// ----------------------------------------------------------------------------
module key_press_long_repeat_events #(
  parameter int unsigned NUM_KEYS = kplre_pkg::NumKeysDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // threshold writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kplre_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kplre_pkg::AgeW-1:0]    cfg_data_i,
  // poll tick items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kplre_pkg::in_item_t           in_item_i,
  // event items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kplre_pkg::out_item_t          out_item_o
);
  import kplre_pkg::*;

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KW-1:0] LastKey = KW'(NUM_KEYS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [KW-1:0]        kidx_q;
  logic [KeyFieldW-1:0] keys_q;
  logic [NUM_KEYS-1:0]  held_q;
  logic [NUM_KEYS-1:0]  long_done_q;
  logic [NUM_KEYS-1:0]  repeating_q;
  logic [AgeW-1:0]      long_age_q;
  logic [AgeW-1:0]      repeat_age_q;
  out_item_t            ev_q;
  out_item_t            out_q;
  logic                 out_valid_q;

  cfg_t                 cfg;
  key_ctx_t             ctx;
  key_res_t             res;
  logic [NUM_KEYS-1:0]  now_vec;
  logic [KeyFieldW-1:0] sel_mask;
  logic                 accept;
  logic                 out_free;

  kplre_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Keys past the input field always read as released
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_now
    if (i < KeyFieldW) begin : g_bit
      assign now_vec[i] = keys_q[i];
    end else begin : g_none
      assign now_vec[i] = 1'b0;
    end
  end

  // Event bit lanes exist only for the first eight keys
  for (genvar j = 0; j < KeyFieldW; j++) begin : g_sel
    if (j < NUM_KEYS) begin : g_key
      assign sel_mask[j] = (kidx_q == KW'(j));
    end else begin : g_none
      assign sel_mask[j] = 1'b0;
    end
  end

  assign ctx.now        = now_vec[kidx_q];
  assign ctx.held       = held_q[kidx_q];
  assign ctx.long_done  = long_done_q[kidx_q];
  assign ctx.repeating  = repeating_q[kidx_q];
  assign ctx.long_age   = long_age_q;
  assign ctx.repeat_age = repeat_age_q;

  kplre_key_step u_step (
    .ctx_i (ctx),
    .cfg_i (cfg),
    .res_o (res)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kidx_q       <= '0;
      held_q       <= '0;
      long_done_q  <= '0;
      repeating_q  <= '0;
      long_age_q   <= '0;
      repeat_age_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // retire the waiting result once taken; the finish step loads its own
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            keys_q       <= in_item_i.pressed_keys;
            kidx_q       <= '0;
            ev_q         <= '0;
            // advance both ages before the walk, saturating
            long_age_q   <= (long_age_q == AgeMax) ? AgeMax : long_age_q + 1'b1;
            repeat_age_q <= (repeat_age_q == AgeMax) ? AgeMax : repeat_age_q + 1'b1;
            state_q      <= in_item_i.listener_present ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          // commit one key; later keys see the restarted ages
          held_q[kidx_q]      <= res.held;
          long_done_q[kidx_q] <= res.long_done;
          repeating_q[kidx_q] <= res.repeating;
          long_age_q          <= res.long_age;
          repeat_age_q        <= res.repeat_age;
          ev_q.press_events      <= ev_q.press_events | (sel_mask & {KeyFieldW{res.ev_press}});
          ev_q.release_events    <= ev_q.release_events |
                                    (sel_mask & {KeyFieldW{res.ev_release}});
          ev_q.long_press_events <= ev_q.long_press_events |
                                    (sel_mask & {KeyFieldW{res.ev_long}});
          ev_q.repeat_events     <= ev_q.repeat_events | (sel_mask & {KeyFieldW{res.ev_repeat}});
          if (kidx_q == LastKey) begin
            state_q <= ST_FINISH;
          end else begin
            kidx_q <= kidx_q + 1'b1;
          end
        end
        ST_FINISH: begin
          // hold here until the output register is free
          if (out_free) begin
            out_q       <= ev_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
